// ----- rtl/mcom_pkg.sv -----
// Shared types and constants for the motor current overload monitor.
// No dependencies; imported by mcom_ema and motor_current_overload_monitor.
`default_nettype none

package mcom_pkg;

  // Default number of monitored motor channels.
  localparam int CHANNELS_DEF = 6;

  // Field and register widths.
  localparam int REQ_W     = 2;
  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 10;
  localparam int Q6_W      = 16;
  localparam int FRAC_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int LIMIT_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Channels 0 through LIMIT_REGS-1 have a limit register.
  localparam int LIMIT_REGS = 6;

  // Filter level for zero amps (775 in Q10.6) and the pre-overload level.
  localparam logic [Q6_W-1:0]     ZERO_AMPS_Q6      = 16'd49600;
  localparam logic [SAMPLE_W-1:0] PREOVERLOAD_LEVEL = 10'd600;

  // Weight reset values, unsigned Q0.16.
  localparam logic [WEIGHT_W-1:0] WEIGHT_PREV_RST = 16'd58982;
  localparam logic [WEIGHT_W-1:0] WEIGHT_PRES_RST = 16'd6554;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PREV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PRES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CH0   = 3'd2;

  // Request types. The fourth code is unused and leaves all state alone.
  typedef enum logic [REQ_W-1:0] {
    REQ_OVERLOAD    = 2'd0,
    REQ_PREOVERLOAD = 2'd1,
    REQ_RESET_ALL   = 2'd2
  } req_t;

endpackage

`default_nettype wire

// ----- rtl/motor_current_overload_monitor.sv -----
// Top level of the motor current overload monitor: input register, filter update
// and trip checks, result register. Depends on mcom_pkg and mcom_ema.
`default_nettype none

// Each input transfer carries a request type, a channel and a 10-bit ADC sample.
// Overload and pre-overload requests update that channel's moving average filter
// (unsigned Q10.6, saturating) and compare its integer part with the channel's
// limit or with 600; a hit sets a sticky flag, and an overload hit also records
// the channel and raises stop_motors for that one result. A reset request puts
// every filter back to 775 (zero amps) and reports a filtered value of zero.
// Requests for a channel that does not exist, and the unused request code, change
// nothing and report zero. Every input transfer produces exactly one result
// transfer. The block takes one item per clock cycle while m_tready does not
// hold the result register; each item passes through the input register and
// then the result register, and the rate is set by the read-modify-write of
// the per-channel filter registers, which lets an item for the same channel
// follow directly. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and should only change while no item is in flight.

module motor_current_overload_monitor
  import mcom_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // [2:0] channel, [12:3] raw_sample
  input  wire logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
  // Result stream.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [15:0]          m_tdata,   // [9:0] filtered_current,
                                               // [12:10] overloaded_channel
  output logic      [2:0]           m_tuser,   // [0] overload_flag,
                                               // [1] preoverload_flag, [2] stop_motors
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [WEIGHT_W-1:0] weight_prev;
  logic [WEIGHT_W-1:0] weight_pres;
  logic [LIMIT_W-1:0]  limit [CHANNELS];

  // Block state.
  logic [Q6_W-1:0] filter_store [CHANNELS];
  logic            overload_latch;
  logic [CH_W-1:0] trip_channel;
  logic            preoverload_latch;

  // Input register.
  logic                s1_valid;
  req_t                s1_type;
  logic [CH_W-1:0]     s1_channel;
  logic [SAMPLE_W-1:0] s1_sample;

  // Result register.
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_filtered;
  logic                out_overload;
  logic [CH_W-1:0]     out_trip_channel;
  logic                out_preoverload;
  logic                out_stop;

  // Datapath between the registers.
  logic                out_free;
  logic                advance;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [Q6_W-1:0]     new_q6;
  logic                store_we;
  logic                reset_all;
  logic [SAMPLE_W-1:0] filtered_next;
  logic                overload_next;
  logic [CH_W-1:0]     trip_channel_next;
  logic                preoverload_next;
  logic                stop_next;

  // The result register frees up when it is empty or being read this cycle;
  // the input register moves on whenever the result register can take its item.
  assign out_free = !out_valid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  // ---------------------------------------------------------------------------
  // Configuration writes. Limits exist only for the first LIMIT_REGS channels;
  // channels beyond that keep a limit of zero.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_prev <= WEIGHT_PREV_RST;
      weight_pres <= WEIGHT_PRES_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        limit[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_WEIGHT_PREV) begin
        weight_prev <= cfg_data[WEIGHT_W-1:0];
      end
      if (cfg_index == REG_WEIGHT_PRES) begin
        weight_pres <= cfg_data[WEIGHT_W-1:0];
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (i < LIMIT_REGS && cfg_index == REG_LIMIT_CH0 + CFG_IDX_W'(i)) begin
          limit[i] <= cfg_data[LIMIT_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_type    <= req_t'(s_tuser);
      s1_channel <= s_tdata[CH_W-1:0];
      s1_sample  <= s_tdata[CH_W+SAMPLE_W-1:CH_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Filter update and trip checks.
  // ---------------------------------------------------------------------------
  assign ch_ok  = 32'(s1_channel) < CHANNELS;
  assign ch_idx = CH_IDX_W'(s1_channel);

  mcom_ema u_ema (
    .prev_q6     (filter_store[ch_idx]),
    .sample      (s1_sample),
    .weight_prev (weight_prev),
    .weight_pres (weight_pres),
    .new_q6      (new_q6)
  );

  always_comb begin
    store_we          = 1'b0;
    reset_all         = 1'b0;
    filtered_next     = '0;
    overload_next     = overload_latch;
    trip_channel_next = trip_channel;
    preoverload_next  = preoverload_latch;
    stop_next         = 1'b0;
    case (s1_type)
      REQ_OVERLOAD: begin
        if (ch_ok) begin
          store_we      = 1'b1;
          filtered_next = new_q6[Q6_W-1:FRAC_W];
          if (filtered_next <= limit[ch_idx]) begin
            overload_next     = 1'b1;
            trip_channel_next = s1_channel;
            stop_next         = 1'b1;
          end
        end
      end
      REQ_PREOVERLOAD: begin
        if (ch_ok) begin
          store_we      = 1'b1;
          filtered_next = new_q6[Q6_W-1:FRAC_W];
          if (filtered_next <= PREOVERLOAD_LEVEL) begin
            preoverload_next = 1'b1;
          end
        end
      end
      REQ_RESET_ALL: begin
        reset_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && reset_all)) begin
      for (int i = 0; i < CHANNELS; i++) begin
        filter_store[i] <= ZERO_AMPS_Q6;
      end
    end else if (advance && store_we) begin
      filter_store[ch_idx] <= new_q6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overload_latch    <= 1'b0;
      trip_channel      <= '0;
      preoverload_latch <= 1'b0;
    end else if (advance) begin
      overload_latch    <= overload_next;
      trip_channel      <= trip_channel_next;
      preoverload_latch <= preoverload_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_filtered     <= filtered_next;
      out_overload     <= overload_next;
      out_trip_channel <= trip_channel_next;
      out_preoverload  <= preoverload_next;
      out_stop         <= stop_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_trip_channel, out_filtered};
  assign m_tuser  = {out_stop, out_preoverload, out_overload};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A stop command always comes with the sticky overload flag set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stop |-> out_overload)
    else $error("stop_motors without overload flag");

  // The sticky flags never clear outside of reset.
  assert property (@(posedge clk) disable iff (rst)
    !$fell(overload_latch) && !$fell(preoverload_latch))
    else $error("sticky flag cleared");

  // Only an overload request for an existing channel can trip.
  assert property (@(posedge clk) disable iff (rst)
    advance && stop_next |-> s1_type == REQ_OVERLOAD && ch_ok)
    else $error("trip from a request that cannot trip");

  // A held item stays in the input register until it moves on.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register lost an item");

  // A reset request reports zero and never trips.
  assert property (@(posedge clk) disable iff (rst)
    advance && reset_all |=> out_filtered == '0 && !out_stop)
    else $error("reset request reported a value");

endmodule

`default_nettype wire

// ----- rtl/mcom_ema.sv -----
// Exponential moving average update for one channel: prev*w_prev + sample*w_pres.
// Depends on mcom_pkg for widths.
`default_nettype none

module mcom_ema
  import mcom_pkg::*;
(
  input  wire logic [Q6_W-1:0]     prev_q6,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [WEIGHT_W-1:0] weight_prev,
  input  wire logic [WEIGHT_W-1:0] weight_pres,
  output logic      [Q6_W-1:0]     new_q6
);

  logic [Q6_W+WEIGHT_W-1:0]     prod_prev;  // Q10.22
  logic [SAMPLE_W+WEIGHT_W-1:0] prod_pres;  // Q10.16
  logic [Q6_W+WEIGHT_W:0]       acc;
  logic [Q6_W:0]                scaled;

  always_comb begin
    prod_prev = prev_q6 * weight_prev;
    prod_pres = sample * weight_pres;
    // Align the sample term to Q10.22 before the sum.
    acc = {1'b0, prod_prev} + {1'b0, prod_pres, {FRAC_W{1'b0}}};
    scaled = acc[Q6_W+WEIGHT_W:WEIGHT_W];
    // Clamp to the largest Q10.6 value on overflow.
    new_q6 = scaled[Q6_W] ? {Q6_W{1'b1}} : scaled[Q6_W-1:0];
  end

endmodule

`default_nettype wire
